// ===== design/fbct_pkg.sv =====
// ----------------------------------------------------------------------------
// fbct_pkg
// Shared constants, types and codes for the frustum / box cull test block.
// ----------------------------------------------------------------------------
package fbct_pkg;

  // Plane store and coordinate format
  localparam int PLANE_COUNT = 6;
  localparam int COORD_WIDTH = 32;
  localparam int FIELD_WIDTH = 32;
  localparam int INDEX_WIDTH = 3;
  localparam int PIDX_W      = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  // Exact dot product arithmetic
  localparam int PROD_W  = 2 * COORD_WIDTH;
  localparam int ACC_W   = 2 * COORD_WIDTH + 3;
  localparam int D_SHIFT = 16;

  // Stream widths
  localparam int IN_FIELD_COUNT = 10;
  localparam int IN_PAYLOAD_W   = INDEX_WIDTH + IN_FIELD_COUNT * FIELD_WIDTH;
  localparam int IN_TDATA_W     = ((IN_PAYLOAD_W + 7) / 8) * 8;
  localparam int VERDICT_W      = 2;
  localparam int OUT_TDATA_W    = ((VERDICT_W + 7) / 8) * 8;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OUTSIDE = 2'd0,
    VERDICT_INSIDE  = 2'd1,
    VERDICT_PARTIAL = 2'd2
  } verdict_e;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
  } plane_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    op_e               op;
    logic [PIDX_W-1:0] idx;
    plane_t            plane;
    box_t              box;
  } entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

// ===== design/fbct_front.sv =====
// ----------------------------------------------------------------------------
// fbct_front
// Input side: accepts stream transactions, unpacks the fields, drops loads
// aimed past the plane store and pushes the rest into the queue.
// ----------------------------------------------------------------------------
module fbct_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic                           s_axis_tuser,  // action
  // plane_index, plane_a, plane_b, plane_c, plane_d,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad
  input  logic [fbct_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  fbct_pkg::q_status_t            q_status_i,
  output logic                           push_o,
  output fbct_pkg::entry_t               entry_o
);

  localparam int OFF_A    = fbct_pkg::INDEX_WIDTH;
  localparam int OFF_B    = OFF_A + fbct_pkg::FIELD_WIDTH;
  localparam int OFF_C    = OFF_B + fbct_pkg::FIELD_WIDTH;
  localparam int OFF_D    = OFF_C + fbct_pkg::FIELD_WIDTH;
  localparam int OFF_MINX = OFF_D + fbct_pkg::FIELD_WIDTH;
  localparam int OFF_MINY = OFF_MINX + fbct_pkg::FIELD_WIDTH;
  localparam int OFF_MINZ = OFF_MINY + fbct_pkg::FIELD_WIDTH;
  localparam int OFF_MAXX = OFF_MINZ + fbct_pkg::FIELD_WIDTH;
  localparam int OFF_MAXY = OFF_MAXX + fbct_pkg::FIELD_WIDTH;
  localparam int OFF_MAXZ = OFF_MAXY + fbct_pkg::FIELD_WIDTH;
  localparam int CW       = fbct_pkg::COORD_WIDTH;

  logic [fbct_pkg::INDEX_WIDTH-1:0] raw_idx;
  logic                             idx_ok;
  logic                             accept;
  fbct_pkg::op_e                    op;

  // Take a transaction whenever the queue has room
  assign s_axis_tready = !q_status_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Classify: tests always go on, loads only for an existing slot
  assign op      = fbct_pkg::op_e'(s_axis_tuser);
  assign raw_idx = s_axis_tdata[fbct_pkg::INDEX_WIDTH-1:0];
  assign idx_ok  = ({1'b0, raw_idx} < (fbct_pkg::INDEX_WIDTH + 1)'(fbct_pkg::PLANE_COUNT));
  assign push_o  = accept && ((op == fbct_pkg::OP_TEST) || idx_ok);

  // Unpack, keeping the low coordinate bits of each field
  always_comb begin
    entry_o.op        = op;
    entry_o.idx       = raw_idx[fbct_pkg::PIDX_W-1:0];
    entry_o.plane.a   = s_axis_tdata[OFF_A +: CW];
    entry_o.plane.b   = s_axis_tdata[OFF_B +: CW];
    entry_o.plane.c   = s_axis_tdata[OFF_C +: CW];
    entry_o.plane.d   = s_axis_tdata[OFF_D +: CW];
    entry_o.box.min_x = s_axis_tdata[OFF_MINX +: CW];
    entry_o.box.min_y = s_axis_tdata[OFF_MINY +: CW];
    entry_o.box.min_z = s_axis_tdata[OFF_MINZ +: CW];
    entry_o.box.max_x = s_axis_tdata[OFF_MAXX +: CW];
    entry_o.box.max_y = s_axis_tdata[OFF_MAXY +: CW];
    entry_o.box.max_z = s_axis_tdata[OFF_MAXZ +: CW];
  end

  // Loads past the store never reach the queue
  a_drop_bad_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && (entry_o.op == fbct_pkg::OP_LOAD)) |-> idx_ok)
    else $error("load for a missing plane slot was queued");

endmodule

// ===== design/fbct_queue.sv =====
// ----------------------------------------------------------------------------
// fbct_queue
// Short in-order queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module fbct_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fbct_pkg::entry_t    entry_i,
  input  logic                pop_i,
  output fbct_pkg::entry_t    entry_o,
  output fbct_pkg::q_status_t status_o
);

  localparam logic [fbct_pkg::QUEUE_AW-1:0] PTR_LAST =
    fbct_pkg::QUEUE_AW'(fbct_pkg::QUEUE_DEPTH - 1);
  localparam logic [fbct_pkg::QUEUE_AW:0] CNT_FULL =
    (fbct_pkg::QUEUE_AW + 1)'(fbct_pkg::QUEUE_DEPTH);

  fbct_pkg::entry_t                mem_q [fbct_pkg::QUEUE_DEPTH];
  logic [fbct_pkg::QUEUE_AW-1:0]   wptr_q, rptr_q;
  logic [fbct_pkg::QUEUE_AW:0]     count_q;
  logic                            do_push, do_pop;

  assign status_o.valid = (count_q != '0);
  assign status_o.full  = (count_q == CNT_FULL);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign entry_o        = mem_q[rptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("queue count beyond depth");

endmodule

// ===== design/fbct_back.sv =====
// ----------------------------------------------------------------------------
// fbct_back
// Execution side: writes loads into the plane store and walks each test box
// through the planes with one shared multiplier and two exact accumulators.
// ----------------------------------------------------------------------------
module fbct_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fbct_pkg::q_status_t              q_status_i,
  input  fbct_pkg::entry_t                 entry_i,
  output logic                             pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [fbct_pkg::OUT_TDATA_W-1:0] m_axis_tdata  // verdict, zero pad
);

  localparam int CW     = fbct_pkg::COORD_WIDTH;
  localparam int ACC_W  = fbct_pkg::ACC_W;
  localparam int PIDX_W = fbct_pkg::PIDX_W;

  // Step sequence of one plane: six products, one trailing add, evaluate
  localparam logic [2:0] STEP_FAR_X    = 3'd0;
  localparam logic [2:0] STEP_FAR_Y    = 3'd1;
  localparam logic [2:0] STEP_FAR_Z    = 3'd2;
  localparam logic [2:0] STEP_NEAR_X   = 3'd3;
  localparam logic [2:0] STEP_NEAR_Y   = 3'd4;
  localparam logic [2:0] STEP_NEAR_Z   = 3'd5;
  localparam logic [2:0] STEP_ACC_LAST = 3'd6;
  localparam logic [2:0] STEP_EVAL     = 3'd7;

  localparam logic [PIDX_W-1:0] PLANE_LAST = PIDX_W'(fbct_pkg::PLANE_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                            state_q;
  fbct_pkg::plane_t                  store_q [fbct_pkg::PLANE_COUNT];
  fbct_pkg::box_t                    box_q;
  logic [PIDX_W-1:0]                 plane_q;
  logic [2:0]                        step_q;
  logic                              partial_q;
  fbct_pkg::verdict_e                result_q;
  fbct_pkg::verdict_e                out_verdict_q;
  logic                              out_valid_q;
  logic signed [fbct_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]           acc_far_q, acc_near_q;

  fbct_pkg::plane_t                  cur;
  logic                              pos_a, pos_b, pos_c;
  fbct_pkg::coord_t                  mul_comp, mul_coord;
  logic signed [ACC_W-1:0]           d_ext, d_init, prod_ext;
  logic                              start_test;

  assign pop_o      = (state_q == ST_IDLE) && q_status_i.valid;
  assign start_test = pop_o && (entry_i.op == fbct_pkg::OP_TEST);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = fbct_pkg::OUT_TDATA_W'(out_verdict_q);

  // Current plane and sign of each normal component
  assign cur   = store_q[plane_q];
  assign pos_a = !cur.a[CW-1] && (cur.a != '0);
  assign pos_b = !cur.b[CW-1] && (cur.b != '0);
  assign pos_c = !cur.c[CW-1] && (cur.c != '0);

  // Pick operands: far corner takes max on a positive component, near the opposite
  always_comb begin
    unique case (step_q)
      STEP_FAR_X: begin
        mul_comp  = cur.a;
        mul_coord = pos_a ? box_q.max_x : box_q.min_x;
      end
      STEP_FAR_Y: begin
        mul_comp  = cur.b;
        mul_coord = pos_b ? box_q.max_y : box_q.min_y;
      end
      STEP_FAR_Z: begin
        mul_comp  = cur.c;
        mul_coord = pos_c ? box_q.max_z : box_q.min_z;
      end
      STEP_NEAR_X: begin
        mul_comp  = cur.a;
        mul_coord = pos_a ? box_q.min_x : box_q.max_x;
      end
      STEP_NEAR_Y: begin
        mul_comp  = cur.b;
        mul_coord = pos_b ? box_q.min_y : box_q.max_y;
      end
      STEP_NEAR_Z: begin
        mul_comp  = cur.c;
        mul_coord = pos_c ? box_q.min_z : box_q.max_z;
      end
      default: begin
        mul_comp  = '0;
        mul_coord = '0;
      end
    endcase
  end

  // Exact product and the offset term scaled to the product's fraction
  assign prod_d   = fbct_pkg::PROD_W'(mul_comp) * fbct_pkg::PROD_W'(mul_coord);
  assign prod_ext = ACC_W'(prod_q);
  assign d_ext    = ACC_W'(cur.d);
  assign d_init   = d_ext <<< fbct_pkg::D_SHIFT;

  // Sequencer, plane store and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      plane_q       <= '0;
      step_q        <= STEP_FAR_X;
      partial_q     <= 1'b0;
      result_q      <= fbct_pkg::VERDICT_INSIDE;
      out_valid_q   <= 1'b0;
      out_verdict_q <= fbct_pkg::VERDICT_INSIDE;
      for (int i = 0; i < fbct_pkg::PLANE_COUNT; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      // Load a finished verdict, or drop one the sink has taken
      if ((state_q == ST_DONE) && (!out_valid_q || m_axis_tready)) begin
        out_valid_q   <= 1'b1;
        out_verdict_q <= result_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_test) begin
            state_q   <= ST_RUN;
            plane_q   <= '0;
            step_q    <= STEP_FAR_X;
            partial_q <= 1'b0;
          end else if (pop_o) begin
            store_q[entry_i.idx] <= entry_i.plane;
          end
        end
        ST_RUN: begin
          if (step_q != STEP_EVAL) begin
            step_q <= step_q + 1'b1;
          end else begin
            step_q <= STEP_FAR_X;
            if (acc_far_q[ACC_W-1]) begin
              result_q <= fbct_pkg::VERDICT_OUTSIDE;
              state_q  <= ST_DONE;
            end else if (plane_q == PLANE_LAST) begin
              result_q <= (partial_q || acc_near_q[ACC_W-1]) ?
                          fbct_pkg::VERDICT_PARTIAL : fbct_pkg::VERDICT_INSIDE;
              state_q  <= ST_DONE;
            end else begin
              partial_q <= partial_q || acc_near_q[ACC_W-1];
              plane_q   <= plane_q + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: latch the box, register the product, accumulate both sums
  always_ff @(posedge clk_i) begin
    if (start_test) begin
      box_q <= entry_i.box;
    end
    prod_q <= prod_d;
    if (state_q == ST_RUN) begin
      if (step_q == STEP_FAR_X) begin
        acc_far_q  <= d_init;
        acc_near_q <= d_init;
      end else if (step_q <= STEP_NEAR_X) begin
        acc_far_q <= acc_far_q + prod_ext;
      end else if (step_q <= STEP_ACC_LAST) begin
        acc_near_q <= acc_near_q + prod_ext;
      end
    end
  end

  a_done_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && $past(state_q) == ST_RUN) |-> $past(step_q) == STEP_EVAL)
    else $error("test finished before a plane was evaluated");

  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (plane_q <= PLANE_LAST))
    else $error("plane counter beyond the store");

  a_outside_matches_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |->
      ((result_q == fbct_pkg::VERDICT_OUTSIDE) == acc_far_q[ACC_W-1]))
    else $error("outside verdict disagrees with far corner sum");

endmodule

// ===== design/frustum_box_cull_test.sv =====
// ----------------------------------------------------------------------------
// frustum_box_cull_test
// Frustum against axis-aligned box classifier with six stored Q16.16 planes.
//
//  Channel  Dir  tuser   tdata (low bit up)
//  s_axis   in   action  plane_index, plane_a..d, box_min_x..z, box_max_x..z
//  m_axis   out  -       verdict (one per test transaction, none per load)
//
//  A load is written into the plane store as the back end pops it. A test
//  visits the stored planes in turn, and each plane needs six products
//  through the single 32 x 32 multiplier, one trailing add and an evaluate
//  step. A plane that rejects the box ends the walk early.
//  Reset clears every plane to zero, so each box reads as fully inside.
//  A two-entry queue lets the input keep taking transactions while a test
//  runs; the output register lets the next item start before a result is taken.
// ----------------------------------------------------------------------------
module frustum_box_cull_test (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic                             s_axis_tuser,  // action
  // plane_index, plane_a, plane_b, plane_c, plane_d,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad
  input  logic [fbct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [fbct_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // verdict, zero pad
);

  fbct_pkg::q_status_t q_status;
  fbct_pkg::entry_t    push_entry, head_entry;
  logic                push, pop;

  // Accept and classify
  fbct_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .q_status_i    (q_status),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  // Decouple front from back
  fbct_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  // Execute loads and tests
  fbct_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
